FILE: rtl/ppu_pkg.sv
// ----------------------------------------------------------------------------
// Packed pixel unpacker package
// Types and constants shared by the front end, the slot walker and the top.
// ----------------------------------------------------------------------------
package ppu_pkg;

  // Item function codes.
  typedef enum logic [0:0] {
    FUNC_PAL_WRITE = 1'b0,
    FUNC_UNPACK    = 1'b1
  } func_e;

  // Pixel depth codes; undefined codes fold onto DEPTH_32.
  typedef enum logic [2:0] {
    DEPTH_1  = 3'd0,
    DEPTH_2  = 3'd1,
    DEPTH_4  = 3'd2,
    DEPTH_8  = 3'd3,
    DEPTH_16 = 3'd4,
    DEPTH_32 = 3'd5
  } depth_e;

  localparam logic [2:0] DepthReset = 3'd5;

  // Queue between the front end and the slot walker.
  localparam int unsigned MidDepth = 2;
  localparam int unsigned MidPtrW  = 1;
  localparam int unsigned MidCntW  = 2;

  // Result queue at the output.
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = 2;
  localparam int unsigned OutCntW  = 3;

  // Input beat.
  typedef struct packed {
    func_e       func;
    logic [31:0] data_word;
    logic [7:0]  palette_index;
    logic [4:0]  first_slot;
    logic [4:0]  last_slot;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [31:0] pixel_color;
    logic [4:0]  slot;
    logic        last_of_word;
  } out_item_t;

  // Classified work record passed from the front end to the slot walker.
  typedef struct packed {
    func_e       func;
    depth_e      depth;
    logic [31:0] data_word;
    logic [7:0]  palette_index;
    logic [4:0]  first_slot;
    logic [4:0]  last_slot;
  } mid_rec_t;

  // Highest slot index of a word at the given depth.
  function automatic logic [4:0] max_slot(depth_e d);
    return 5'(5'd31 >> d);
  endfunction

  // RGB555 to RGB888 expansion by replicating the top bits of each channel.
  function automatic logic [31:0] expand_555(logic [14:0] w);
    return {8'h00, w[14:10], w[14:12], w[9:5], w[9:7], w[4:0], w[4:2]};
  endfunction

endpackage

FILE: rtl/packed_pixel_unpacker.sv
// ----------------------------------------------------------------------------
// Packed pixel unpacker
// Splits 32-bit framebuffer words into per-pixel colours via a palette,
// RGB555 expansion or pass-through, depending on the configured depth.
// ----------------------------------------------------------------------------
// Push a beat while full is low; results appear in order while empty is low
// and leave on pop. An unpack beat produces one result per slot in its
// clamped range (up to 32 at 1 bit per pixel), at one result per cycle
// while the result queue has room; the rate is set by the slot walker,
// which issues one palette read or expansion per cycle unless the result
// queue is full. A palette write produces no result; an empty range is
// dropped at the input. Every result passes through one lookup stage
// aligned with the registered palette RAM read, at all depths. A two-beat
// work queue sits between input and walker, and a four-beat result queue
// at the output. The palette is not cleared after reset: only entries that
// have been written may be looked up. Write depth_code only while the
// block is idle.
module packed_pixel_unpacker #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_data_i,
  input  logic               push,
  output logic               full,
  input  ppu_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output ppu_pkg::out_item_t out_item_o
);

  logic              mid_valid;
  ppu_pkg::mid_rec_t mid_rec;
  logic              mid_take;

  // Front end: depth register, classification and work queue.
  ppu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .mid_valid_o (mid_valid),
    .mid_rec_o   (mid_rec),
    .mid_take_i  (mid_take)
  );

  // Back end: slot walker, palette and result queue.
  ppu_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_rec_i   (mid_rec),
    .mid_take_o  (mid_take),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/ppu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ppu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ppu_front.sv
// ----------------------------------------------------------------------------
// Packed pixel unpacker front end
// Holds the depth register, classifies input beats, clamps the slot range,
// drops empty ranges and queues the work records for the slot walker.
// ----------------------------------------------------------------------------
module ppu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_data_i,
  input  logic              push,
  output logic              full,
  input  ppu_pkg::in_item_t in_item_i,
  output logic              mid_valid_o,
  output ppu_pkg::mid_rec_t mid_rec_o,
  input  logic              mid_take_i
);

  logic [2:0]                   depth_q;
  ppu_pkg::depth_e              depth;
  ppu_pkg::mid_rec_t            rec;
  logic [4:0]                   top_slot;
  logic                         accept;
  logic                         enqueue;

  ppu_pkg::mid_rec_t            mem_q [ppu_pkg::MidDepth];
  logic [ppu_pkg::MidPtrW-1:0]  wptr_q, wptr_d;
  logic [ppu_pkg::MidPtrW-1:0]  rptr_q, rptr_d;
  logic [ppu_pkg::MidCntW-1:0]  cnt_q, cnt_d;

  // Depth register; undefined codes act as 32 bits per pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= ppu_pkg::DepthReset;
    end else if (cfg_we_i) begin
      depth_q <= cfg_data_i;
    end
  end

  always_comb begin
    unique case (depth_q)
      3'd0:    depth = ppu_pkg::DEPTH_1;
      3'd1:    depth = ppu_pkg::DEPTH_2;
      3'd2:    depth = ppu_pkg::DEPTH_4;
      3'd3:    depth = ppu_pkg::DEPTH_8;
      3'd4:    depth = ppu_pkg::DEPTH_16;
      default: depth = ppu_pkg::DEPTH_32;
    endcase
  end

  // Classification: clamp the last slot to the word's pixel count.
  assign top_slot = ppu_pkg::max_slot(depth);

  always_comb begin
    rec.func          = in_item_i.func;
    rec.depth         = depth;
    rec.data_word     = in_item_i.data_word;
    rec.palette_index = in_item_i.palette_index;
    rec.first_slot    = in_item_i.first_slot;
    rec.last_slot     = (in_item_i.last_slot > top_slot) ? top_slot : in_item_i.last_slot;
  end

  // An unpack beat with an empty range is taken and dropped.
  assign accept  = push && !full;
  assign enqueue = accept &&
                   !((in_item_i.func == ppu_pkg::FUNC_UNPACK) &&
                     (rec.first_slot > rec.last_slot));

  // Work queue pointers and fill count.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (enqueue) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (mid_take_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (enqueue && !mid_take_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!enqueue && mid_take_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Work queue storage.
  always_ff @(posedge clk_i) begin
    if (enqueue) begin
      mem_q[wptr_q] <= rec;
    end
  end

  assign full        = (cnt_q == ppu_pkg::MidCntW'(ppu_pkg::MidDepth));
  assign mid_valid_o = (cnt_q != '0);
  assign mid_rec_o   = mem_q[rptr_q];

endmodule

FILE: rtl/ppu_back.sv
// ----------------------------------------------------------------------------
// Packed pixel unpacker slot walker
// Carries out work records: palette writes, and one pixel slot per cycle for
// unpack records while the result queue has room, through the palette RAM into the result queue.
// ----------------------------------------------------------------------------
module ppu_back #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mid_valid_i,
  input  ppu_pkg::mid_rec_t  mid_rec_i,
  output logic               mid_take_o,
  output logic               empty,
  input  logic               pop,
  output ppu_pkg::out_item_t out_item_o
);

  localparam int unsigned AddrW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // Current record and slot counter.
  logic              busy_q, busy_d;
  ppu_pkg::mid_rec_t cur_q, cur_d;
  logic [4:0]        slot_q, slot_d;

  logic              issue;
  logic              pal_wr;
  logic              done;
  logic              take;
  logic [4:0]        shift;
  logic [31:0]       shifted;
  logic [7:0]        field;
  logic              is_pal;
  logic [31:0]       direct_color;
  logic [AddrW-1:0]  rd_addr;
  logic [31:0]       rd_data;
  logic              wr_en;

  // Lookup stage registers.
  logic              s1_valid_q;
  logic              s1_pal_q;
  logic              s1_oob_q;
  logic [31:0]       s1_color_q;
  logic [4:0]        s1_slot_q;
  logic              s1_last_q;

  // Result queue.
  ppu_pkg::out_item_t          fifo_q [ppu_pkg::OutDepth];
  ppu_pkg::out_item_t          push_item;
  logic [ppu_pkg::OutPtrW-1:0] wptr_q, rptr_q;
  logic [ppu_pkg::OutCntW-1:0] cnt_q, cnt_d;
  logic [ppu_pkg::OutCntW:0]   committed;
  logic                        pop_ok;

  // A slot is issued only when the result queue has room for it and for
  // the beat still in the lookup stage.
  assign committed = {1'b0, cnt_q} + {{ppu_pkg::OutCntW{1'b0}}, s1_valid_q};
  assign issue     = busy_q && (cur_q.func == ppu_pkg::FUNC_UNPACK) &&
                     (committed < (ppu_pkg::OutCntW + 1)'(ppu_pkg::OutDepth));
  assign pal_wr    = busy_q && (cur_q.func == ppu_pkg::FUNC_PAL_WRITE);
  assign done      = pal_wr || (issue && (slot_q == cur_q.last_slot));
  assign take      = mid_valid_i && (!busy_q || done);
  assign mid_take_o = take;

  // Record sequencing.
  always_comb begin
    busy_d = busy_q;
    cur_d  = cur_q;
    slot_d = slot_q;
    if (take) begin
      busy_d = 1'b1;
      cur_d  = mid_rec_i;
      slot_d = mid_rec_i.first_slot;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (issue) begin
      slot_d = slot_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    slot_q <= slot_d;
  end

  // Field extraction: slot 0 sits in the most significant bits.
  assign shift   = 5'((ppu_pkg::max_slot(cur_q.depth) - slot_q) << cur_q.depth);
  assign shifted = cur_q.data_word >> shift;

  always_comb begin
    field        = '0;
    is_pal       = 1'b1;
    direct_color = cur_q.data_word;
    unique case (cur_q.depth)
      ppu_pkg::DEPTH_1:  field = {7'b0, shifted[0]};
      ppu_pkg::DEPTH_2:  field = {6'b0, shifted[1:0]};
      ppu_pkg::DEPTH_4:  field = {4'b0, shifted[3:0]};
      ppu_pkg::DEPTH_8:  field = shifted[7:0];
      ppu_pkg::DEPTH_16: begin
        is_pal       = 1'b0;
        direct_color = ppu_pkg::expand_555(shifted[14:0]);
      end
      default: begin
        is_pal       = 1'b0;
        direct_color = cur_q.data_word;
      end
    endcase
  end

  // Palette memory.
  assign rd_addr = field[AddrW-1:0];
  assign wr_en   = pal_wr &&
                   ({1'b0, cur_q.palette_index} < 9'(PALETTE_ENTRIES));

  ppu_ram #(
    .Width (32),
    .Depth (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cur_q.palette_index[AddrW-1:0]),
    .wdata_i (cur_q.data_word),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Lookup stage, aligned with the registered palette read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pal_q   <= is_pal;
    s1_oob_q   <= ({1'b0, field} >= 9'(PALETTE_ENTRIES));
    s1_color_q <= direct_color;
    s1_slot_q  <= slot_q;
    s1_last_q  <= (slot_q == cur_q.last_slot);
  end

  always_comb begin
    push_item.slot         = s1_slot_q;
    push_item.last_of_word = s1_last_q;
    if (s1_pal_q) begin
      push_item.pixel_color = s1_oob_q ? 32'h0 : rd_data;
    end else begin
      push_item.pixel_color = s1_color_q;
    end
  end

  // Result queue bookkeeping.
  assign pop_ok = pop && !empty;

  always_comb begin
    cnt_d = cnt_q;
    if (s1_valid_q && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!s1_valid_q && pop_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (s1_valid_q) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_ok) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fifo_q[wptr_q] <= push_item;
    end
  end

  assign empty      = (cnt_q == '0);
  assign out_item_o = fifo_q[rptr_q];

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packed pixel unpacker testbench
// Sends palette writes and pixel words at every depth setting. It forecasts
// each colour beat from a shadow palette and depth register, and checks the
// result beats in order against that forecast. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  // Depth codes outside the defined set; the block treats them as 32 bpp.
  localparam logic [2:0] DepthCode6 = 3'd6;
  localparam logic [2:0] DepthCode7 = 3'd7;

  // Cycles to let the work queue and the walker empty out after the last
  // result. Palette writes ahead of a register write give no result of
  // their own.
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned PhaseBeats  = 20;
  localparam int unsigned ReportMax   = 10;

  typedef struct {
    logic [2:0]        depth;
    ppu_pkg::in_item_t beat;
    bit                known;
    logic [31:0]       color;
  } step_t;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               cfg_we   = 1'b0;
  logic [2:0]         cfg_data = '0;
  logic               push     = 1'b0;
  logic               pop      = 1'b0;
  ppu_pkg::in_item_t  in_beat  = '0;
  logic               full;
  logic               empty;
  ppu_pkg::out_item_t out_beat;

  // Shadow state of the block.
  logic [31:0]        pal_shadow [256];
  bit                 pal_written [256];
  logic [2:0]         depth_shadow = ppu_pkg::DepthReset;
  ppu_pkg::out_item_t pixel_forecast [$];

  int failures     = 0;
  int quiet_cycles = 0;
  int burst_left   = 0;
  int hold_left    = 0;
  int pattern_left = 0;
  bit calm         = 1'b0;

  packed_pixel_unpacker uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .in_item_i  (in_beat),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_beat)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The undefined codes fold onto 32 bpp.
  function automatic ppu_pkg::depth_e eff_depth(logic [2:0] code);
    return (code > ppu_pkg::DEPTH_32) ? ppu_pkg::DEPTH_32 : ppu_pkg::depth_e'(code);
  endfunction

  // Last slot after clamping to the pixel count of the word.
  function automatic int unsigned slot_top(ppu_pkg::depth_e d, logic [4:0] last);
    int unsigned lim;
    lim = (32 >> d) - 1;
    return (last > lim) ? lim : last;
  endfunction

  // Pixel field of a slot; slot 0 sits in the most significant bits.
  function automatic logic [31:0] pixel_field(logic [31:0] w, ppu_pkg::depth_e d,
                                              int unsigned s);
    int unsigned bpp;
    int unsigned shift;
    logic [31:0] mask;
    bpp   = 1 << d;
    shift = bpp * ((32 >> d) - 1 - s);
    mask  = (bpp == 32) ? 32'hffff_ffff : (32'd1 << bpp) - 32'd1;
    return (w >> shift) & mask;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= ReportMax) $display("mismatch: %s", msg);
  endfunction

  // Work out the colour beats of one accepted beat and queue them. A known
  // colour from the directed table replaces the computed one.
  task automatic forecast_word(input ppu_pkg::in_item_t b, input bit known,
                               input logic [31:0] kcolor);
    ppu_pkg::depth_e    d;
    int unsigned        top;
    logic [31:0]        field;
    logic [31:0]        color;
    ppu_pkg::out_item_t px;
    if (b.func == ppu_pkg::FUNC_PAL_WRITE) begin
      pal_shadow[b.palette_index]  = b.data_word;
      pal_written[b.palette_index] = 1'b1;
    end else begin
      d   = eff_depth(depth_shadow);
      top = slot_top(d, b.last_slot);
      for (int unsigned s = b.first_slot; s <= top; s++) begin
        field = pixel_field(b.data_word, d, s);
        case (d)
          ppu_pkg::DEPTH_16: begin
            color = ((field & 32'h7c00) << 9) | ((field & 32'h7000) << 4) |
                    ((field & 32'h03e0) << 6) | ((field & 32'h0380) << 1) |
                    ((field & 32'h001f) << 3) | ((field & 32'h001f) >> 2);
          end
          ppu_pkg::DEPTH_32: begin
            color = b.data_word;
          end
          default: begin
            color = pal_shadow[field[7:0]];
          end
        endcase
        px.pixel_color  = known ? kcolor : color;
        px.slot         = s[4:0];
        px.last_of_word = (s == top);
        pixel_forecast.push_back(px);
      end
    end
  endtask

  // Offer one beat, opening a new burst after a random gap where the last
  // one has run out, and forecast it once it is taken.
  task automatic send_beat(input ppu_pkg::in_item_t b, input bit known,
                           input logic [31:0] kcolor);
    int unsigned gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    push    <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (full);
    forecast_word(b, known, kcolor);
    burst_left--;
  endtask

  // Hold the sender until every forecast beat has arrived and the walker
  // has finished any trailing palette writes.
  task automatic wait_drained();
    push <= 1'b0;
    burst_left = 0;
    while (pixel_forecast.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_depth(input logic [2:0] code);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    depth_shadow = code;
  endtask

  function automatic step_t make_step(logic [2:0] dep, ppu_pkg::func_e f, logic [31:0] w,
                                      logic [7:0] idx, logic [4:0] fs, logic [4:0] ls,
                                      bit kn, logic [31:0] c);
    step_t r;
    r.depth              = dep;
    r.beat.func          = f;
    r.beat.data_word     = w;
    r.beat.palette_index = idx;
    r.beat.first_slot    = fs;
    r.beat.last_slot     = ls;
    r.known              = kn;
    r.color              = c;
    return r;
  endfunction

  // Compare each result beat with the oldest forecast beat.
  always @(posedge clk) begin
    ppu_pkg::out_item_t want;
    if (rst_n && pop && !empty) begin
      if (pixel_forecast.size() == 0) begin
        note_failure($sformatf("unexpected beat: colour %h slot %0d last %0b",
                               out_beat.pixel_color, out_beat.slot, out_beat.last_of_word));
      end else begin
        want = pixel_forecast.pop_front();
        if (out_beat.pixel_color !== want.pixel_color || out_beat.slot !== want.slot ||
            out_beat.last_of_word !== want.last_of_word) begin
          note_failure($sformatf("expected colour %h slot %0d last %0b, got %h slot %0d last %0b",
                                 want.pixel_color, want.slot, want.last_of_word,
                                 out_beat.pixel_color, out_beat.slot, out_beat.last_of_word));
        end
      end
    end
  end

  // Receiver stalls: calm stretches with pop held high, and busy stretches
  // with stalls of random length.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pattern_left <= 0) begin
        calm         = ($urandom_range(0, 2) == 0);
        pattern_left = $urandom_range(50, 300);
      end
      pattern_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 16);
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    step_t             plan [25];
    logic [2:0]        phase_depth [8];
    ppu_pkg::in_item_t b;
    ppu_pkg::in_item_t wb;
    ppu_pkg::depth_e   d;
    int unsigned       first;
    int unsigned       last;
    int unsigned       cnt;
    int unsigned       top;
    logic [31:0]       field;

    plan = '{
      // Pass-through at the reset depth, with clamping and an empty range.
      make_step(ppu_pkg::DEPTH_32, ppu_pkg::FUNC_UNPACK, 32'hffff_ffff, 8'h00, 5'd0, 5'd31,
                1'b1, 32'hffff_ffff),
      make_step(ppu_pkg::DEPTH_32, ppu_pkg::FUNC_UNPACK, 32'h0000_0000, 8'hff, 5'd0, 5'd0,
                1'b1, 32'h0000_0000),
      make_step(ppu_pkg::DEPTH_32, ppu_pkg::FUNC_UNPACK, 32'ha5a5_a5a5, 8'h00, 5'd1, 5'd31,
                1'b0, 32'h0),
      // RGB555 expansion: full white, black, pure red and green, bit 15 ignored.
      make_step(ppu_pkg::DEPTH_16, ppu_pkg::FUNC_UNPACK, 32'hffff_ffff, 8'h00, 5'd0, 5'd31,
                1'b1, 32'h00ff_ffff),
      make_step(ppu_pkg::DEPTH_16, ppu_pkg::FUNC_UNPACK, 32'h0000_0000, 8'h00, 5'd0, 5'd1,
                1'b1, 32'h0000_0000),
      make_step(ppu_pkg::DEPTH_16, ppu_pkg::FUNC_UNPACK, 32'h7c00_03e0, 8'h00, 5'd0, 5'd1,
                1'b0, 32'h0),
      make_step(ppu_pkg::DEPTH_16, ppu_pkg::FUNC_UNPACK, 32'h001f_8000, 8'h00, 5'd1, 5'd5,
                1'b1, 32'h0000_0000),
      make_step(ppu_pkg::DEPTH_16, ppu_pkg::FUNC_UNPACK, 32'h1234_5678, 8'h00, 5'd1, 5'd0,
                1'b0, 32'h0),
      // Palette loads, then lookups at 8 bpp.
      make_step(ppu_pkg::DEPTH_8, ppu_pkg::FUNC_PAL_WRITE, 32'hdead_beef, 8'h00, 5'd0, 5'd0,
                1'b0, 32'h0),
      make_step(ppu_pkg::DEPTH_8, ppu_pkg::FUNC_PAL_WRITE, 32'hffff_ffff, 8'hff, 5'd31, 5'd31,
                1'b0, 32'h0),
      make_step(ppu_pkg::DEPTH_8, ppu_pkg::FUNC_PAL_WRITE, 32'h0123_4567, 8'h5a, 5'd0, 5'd0,
                1'b0, 32'h0),
      make_step(ppu_pkg::DEPTH_8, ppu_pkg::FUNC_UNPACK, 32'h0000_0000, 8'h00, 5'd0, 5'd31,
                1'b1, 32'hdead_beef),
      make_step(ppu_pkg::DEPTH_8, ppu_pkg::FUNC_UNPACK, 32'hffff_ffff, 8'h00, 5'd3, 5'd3,
                1'b1, 32'hffff_ffff),
      make_step(ppu_pkg::DEPTH_8, ppu_pkg::FUNC_UNPACK, 32'h5a00_ff5a, 8'h00, 5'd0, 5'd3,
                1'b0, 32'h0),
      // One bit per pixel: a whole word, then the rightmost slot alone.
      make_step(ppu_pkg::DEPTH_1, ppu_pkg::FUNC_PAL_WRITE, 32'h0000_0001, 8'h01, 5'd0, 5'd0,
                1'b0, 32'h0),
      make_step(ppu_pkg::DEPTH_1, ppu_pkg::FUNC_UNPACK, 32'h0000_0000, 8'h00, 5'd0, 5'd31,
                1'b1, 32'hdead_beef),
      make_step(ppu_pkg::DEPTH_1, ppu_pkg::FUNC_UNPACK, 32'hffff_ffff, 8'h00, 5'd31, 5'd31,
                1'b1, 32'h0000_0001),
      // Two and four bits per pixel.
      make_step(ppu_pkg::DEPTH_2, ppu_pkg::FUNC_PAL_WRITE, 32'h8000_0000, 8'h02, 5'd0, 5'd0,
                1'b0, 32'h0),
      make_step(ppu_pkg::DEPTH_2, ppu_pkg::FUNC_PAL_WRITE, 32'h7fff_ffff, 8'h03, 5'd0, 5'd0,
                1'b0, 32'h0),
      make_step(ppu_pkg::DEPTH_2, ppu_pkg::FUNC_UNPACK, 32'he4e4_e4e4, 8'h00, 5'd0, 5'd15,
                1'b0, 32'h0),
      make_step(ppu_pkg::DEPTH_4, ppu_pkg::FUNC_PAL_WRITE, 32'h0f0f_0f0f, 8'h0f, 5'd0, 5'd0,
                1'b0, 32'h0),
      make_step(ppu_pkg::DEPTH_4, ppu_pkg::FUNC_UNPACK, 32'h0123_ff00, 8'h00, 5'd2, 5'd20,
                1'b0, 32'h0),
      // Undefined depth codes pass the word through; a write still gives nothing.
      make_step(DepthCode6, ppu_pkg::FUNC_UNPACK, 32'h1357_9bdf, 8'h00, 5'd0, 5'd31,
                1'b1, 32'h1357_9bdf),
      make_step(DepthCode7, ppu_pkg::FUNC_UNPACK, 32'hffff_ffff, 8'h00, 5'd0, 5'd0,
                1'b1, 32'hffff_ffff),
      make_step(DepthCode7, ppu_pkg::FUNC_PAL_WRITE, 32'h55aa_55aa, 8'h80, 5'd0, 5'd0,
                1'b0, 32'h0)
    };
    phase_depth = '{ppu_pkg::DEPTH_1, ppu_pkg::DEPTH_16, ppu_pkg::DEPTH_2, DepthCode7,
                    ppu_pkg::DEPTH_4, ppu_pkg::DEPTH_32, ppu_pkg::DEPTH_8, DepthCode6};

    // Hold reset, then release it at a rising edge.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (plan[i]) begin
      if (plan[i].depth != depth_shadow) set_depth(plan[i].depth);
      send_beat(plan[i].beat, plan[i].known, plan[i].color);
    end

    // Random phases, one per depth setting.
    foreach (phase_depth[ph]) begin
      set_depth(phase_depth[ph]);
      d   = eff_depth(depth_shadow);
      cnt = 32 >> d;
      for (int n = 0; n < PhaseBeats; n++) begin
        b.func          = ($urandom_range(0, 3) == 0) ? ppu_pkg::FUNC_PAL_WRITE
                                                      : ppu_pkg::FUNC_UNPACK;
        b.data_word     = $urandom;
        b.palette_index = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 6))
          0: begin
            first = 0;
            last  = 31;
          end
          1: begin
            first = $urandom_range(0, 31);
            last  = $urandom_range(0, 31);
          end
          default: begin
            first = $urandom_range(0, cnt - 1);
            last  = $urandom_range(first, 31);
          end
        endcase
        b.first_slot = first[4:0];
        b.last_slot  = last[4:0];
        // Load any palette entry that this word would look up unwritten.
        if (b.func == ppu_pkg::FUNC_UNPACK && d <= ppu_pkg::DEPTH_8) begin
          top = slot_top(d, b.last_slot);
          for (int unsigned s = first; s <= top; s++) begin
            field = pixel_field(b.data_word, d, s);
            if (!pal_written[field[7:0]]) begin
              wb.func          = ppu_pkg::FUNC_PAL_WRITE;
              wb.data_word     = $urandom;
              wb.palette_index = field[7:0];
              wb.first_slot    = 5'($urandom_range(0, 31));
              wb.last_slot     = 5'($urandom_range(0, 31));
              send_beat(wb, 1'b0, 32'h0);
            end
          end
        end
        send_beat(b, 1'b0, 32'h0);
      end
    end

    // Let everything drain, then report.
    wait_drained();
    if (pixel_forecast.size() != 0) begin
      failures += pixel_forecast.size();
      $display("mismatch: %0d forecast beats never arrived", pixel_forecast.size());
    end
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ppu_pkg.sv
rtl/ppu_ram.sv
rtl/ppu_front.sv
rtl/ppu_back.sv
rtl/packed_pixel_unpacker.sv
bench/testbench.sv
